// ===== hw/rtl/lslf_pkg.sv =====
// ----------------------------------------------------------------------------
// lslf_pkg: shared types and constants of the least-squares line fit core
// Result format, output widths and the accumulator count width helper.
// ----------------------------------------------------------------------------
package lslf_pkg;

  localparam int SLOPE_W = 32;   // signed Q16.16
  localparam int ICPT_W  = 48;   // signed Q32.16
  localparam int FRAC_W  = 16;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic signed [ICPT_W-1:0]  ICPT_MAX  = {1'b0, {(ICPT_W-1){1'b1}}};
  localparam logic signed [ICPT_W-1:0]  ICPT_MIN  = {1'b1, {(ICPT_W-1){1'b0}}};

  typedef struct packed {
    logic                      saturated;
    logic                      singular;
    logic signed [ICPT_W-1:0]  intercept;
    logic signed [SLOPE_W-1:0] slope;
  } lslf_result_t;

  // Width of the point counter: holds two points per segment up to the cap.
  function automatic int lslf_cnt_w(input int max_segments);
    return $clog2(2 * max_segments + 1);
  endfunction

endpackage

// ===== hw/rtl/lslf_fifo.sv =====
// ----------------------------------------------------------------------------
// lslf_fifo: two-entry queue between the accumulator and the solver
// Holds frozen sums of finished sets so both sides stall independently.
// ----------------------------------------------------------------------------
module lslf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/lslf_front.sv =====
// ----------------------------------------------------------------------------
// lslf_front: segment intake and running sums
// Registers the endpoint products, then accumulates n, Sx, Sy, Sxx and Sxy;
// on the last segment of a set pushes the frozen sums and clears them.
// ----------------------------------------------------------------------------
module lslf_front import lslf_pkg::*; #(
  parameter  int MAX_SEGMENTS = 1024,
  parameter  int COORD_BITS   = 14,
  localparam int CNT_W        = lslf_cnt_w(MAX_SEGMENTS),
  localparam int SUM_W        = COORD_BITS + CNT_W,
  localparam int SQ_W         = 2 * COORD_BITS + CNT_W,
  localparam int SNAP_W       = 2 * SQ_W + 2 * SUM_W + CNT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  last_segment,
  output logic                  push,
  output logic [SNAP_W-1:0]     push_data,
  input  logic                  push_full
);

  localparam int PR_W = 2 * COORD_BITS;
  localparam int P2_W = PR_W + 1;
  localparam int C2_W = COORD_BITS + 1;

  // product stage
  logic            s1_valid_r;
  logic            s1_last_r;
  logic [P2_W-1:0] s1_sq_r;
  logic [P2_W-1:0] s1_xy_r;
  logic [C2_W-1:0] s1_sx_r;
  logic [C2_W-1:0] s1_sy_r;
  logic            s1_adv;

  // accumulators
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sx_r;
  logic [SUM_W-1:0] sy_r;
  logic [SQ_W-1:0]  sxx_r;
  logic [SQ_W-1:0]  sxy_r;

  logic [CNT_W-1:0] cnt_nxt;
  logic [SUM_W-1:0] sx_nxt;
  logic [SUM_W-1:0] sy_nxt;
  logic [SQ_W-1:0]  sxx_nxt;
  logic [SQ_W-1:0]  sxy_nxt;
  logic             room;

  logic [PR_W-1:0] sq0, sq1, xy0, xy1;

  assign s1_adv   = s1_valid_r && (!s1_last_r || !push_full);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    sq0 = PR_W'(start_x) * PR_W'(start_x);
    sq1 = PR_W'(end_x) * PR_W'(end_x);
    xy0 = PR_W'(start_x) * PR_W'(start_y);
    xy1 = PR_W'(end_x) * PR_W'(end_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_last_r <= last_segment;
      s1_sq_r   <= P2_W'(sq0) + P2_W'(sq1);
      s1_xy_r   <= P2_W'(xy0) + P2_W'(xy1);
      s1_sx_r   <= C2_W'(start_x) + C2_W'(end_x);
      s1_sy_r   <= C2_W'(start_y) + C2_W'(end_y);
    end
  end

  // Drop segments beyond the cap; the last mark still closes the set.
  always_comb begin
    room    = cnt_r[CNT_W-1:1] < (CNT_W-1)'(MAX_SEGMENTS);
    cnt_nxt = room ? cnt_r + CNT_W'(2) : cnt_r;
    sx_nxt  = sx_r + (room ? SUM_W'(s1_sx_r) : '0);
    sy_nxt  = sy_r + (room ? SUM_W'(s1_sy_r) : '0);
    sxx_nxt = sxx_r + (room ? SQ_W'(s1_sq_r) : '0);
    sxy_nxt = sxy_r + (room ? SQ_W'(s1_xy_r) : '0);
  end

  assign push      = s1_adv && s1_last_r;
  assign push_data = {sxy_nxt, sxx_nxt, sy_nxt, sx_nxt, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxx_r <= '0;
        sxy_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        sxx_r <= sxx_nxt;
        sxy_r <= sxy_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/lslf_back.sv =====
// ----------------------------------------------------------------------------
// lslf_back: normal-equation solver
// Forms six products with a shift-add multiplier, then two rounded quotients
// with a restoring divider; saturates and holds the result in an output register.
// ----------------------------------------------------------------------------
module lslf_back import lslf_pkg::*; #(
  parameter  int MAX_SEGMENTS = 1024,
  parameter  int COORD_BITS   = 14,
  localparam int CNT_W        = lslf_cnt_w(MAX_SEGMENTS),
  localparam int SUM_W        = COORD_BITS + CNT_W,
  localparam int SQ_W         = 2 * COORD_BITS + CNT_W,
  localparam int SNAP_W       = 2 * SQ_W + 2 * SUM_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [SNAP_W-1:0] q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lslf_result_t      out_result
);

  localparam int PROD_W = SQ_W + SUM_W;
  localparam int DVD_W  = PROD_W + FRAC_W + 1;
  localparam int QW     = (DVD_W > ICPT_W + 1) ? DVD_W : ICPT_W + 1;
  localparam int BC_W   = $clog2(QW);

  // product slots
  localparam logic [2:0] PR_NXX  = 3'd0;  // n * Sxx
  localparam logic [2:0] PR_SXSX = 3'd1;  // Sx * Sx
  localparam logic [2:0] PR_NXY  = 3'd2;  // n * Sxy
  localparam logic [2:0] PR_SXSY = 3'd3;  // Sx * Sy
  localparam logic [2:0] PR_XXSY = 3'd4;  // Sxx * Sy
  localparam logic [2:0] PR_SXXY = 3'd5;  // Sx * Sxy

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_DET, S_NUM, S_RND, S_DIV, S_SAT
  } state_t;
  localparam state_t S_OUT_ALIAS = S_IDLE;

  typedef enum logic {Q_SLOPE, Q_ICPT} qsel_t;

  state_t           state_r;
  logic             out_pend_r;
  logic [2:0]       sel_r;
  logic [BC_W-1:0]  bit_r;
  qsel_t            qsel_r;
  logic [CNT_W-1:0] n_r;
  logic [SUM_W-1:0] sx_r, sy_r;
  logic [SQ_W-1:0]  sxx_r, sxy_r;
  logic [SQ_W-1:0]  mcand_r;
  logic [SUM_W-1:0] mplier_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] prod_r [6];
  logic [PROD_W-1:0] det_r;
  logic              neg_r;
  logic [PROD_W-1:0] mag_r;
  logic [QW-1:0]     dvd_r;
  logic [PROD_W-1:0] rem_r;
  logic [QW-1:0]     quo_r;
  logic              sat_r;
  lslf_result_t      res_r;
  logic              out_valid_r;
  lslf_result_t      out_res_r;

  logic [PROD_W-1:0] acc_step;
  logic [PROD_W:0]   rem_sh;
  logic [PROD_W+1:0] rem_dif;
  logic              rem_ge;
  logic [PROD_W-1:0] pa, pb, d_ab, d_ba;
  logic              lt;
  logic [QW-1:0]     lim, quo_neg;
  logic              ovf;
  logic [SLOPE_W-1:0] slope_val;
  logic [ICPT_W-1:0]  icpt_val;
  logic               out_free;
  logic               out_load;

  assign out_free   = !out_valid_r || out_ready;
  assign out_load   = (state_r == S_IDLE) && out_pend_r && out_free;
  assign q_pop      = (state_r == S_IDLE) && !out_pend_r && !q_empty;
  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  always_comb begin
    acc_step = (acc_r << 1) + (mplier_r[SUM_W-1] ? PROD_W'(mcand_r) : '0);
    rem_sh   = {rem_r, dvd_r[QW-1]};
    rem_dif  = {1'b0, rem_sh} - {2'b00, det_r};
    rem_ge   = !rem_dif[PROD_W+1];
    pa       = (qsel_r == Q_ICPT) ? prod_r[PR_XXSY] : prod_r[PR_NXY];
    pb       = (qsel_r == Q_ICPT) ? prod_r[PR_SXXY] : prod_r[PR_SXSY];
    d_ab     = pa - pb;
    d_ba     = pb - pa;
    lt       = pa < pb;
    lim      = (qsel_r == Q_ICPT) ? (QW'(1) << (ICPT_W - 1)) : (QW'(1) << (SLOPE_W - 1));
    quo_neg  = QW'(0) - quo_r;
    ovf      = neg_r ? (quo_r > lim) : (quo_r >= lim);
    if (ovf) begin
      slope_val = neg_r ? SLOPE_MIN : SLOPE_MAX;
      icpt_val  = neg_r ? ICPT_MIN : ICPT_MAX;
    end else begin
      slope_val = neg_r ? quo_neg[SLOPE_W-1:0] : quo_r[SLOPE_W-1:0];
      icpt_val  = neg_r ? quo_neg[ICPT_W-1:0] : quo_r[ICPT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          // a finished result waits here until the output register frees up
          if (out_pend_r) begin
            if (out_free) begin
              out_res_r  <= res_r;
              out_pend_r <= 1'b0;
            end
          end else if (!q_empty) begin
            {sxy_r, sxx_r, sy_r, sx_r, n_r} <= q_data;
            sel_r   <= PR_NXX;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          case (sel_r)
            PR_NXX:  begin mcand_r <= sxx_r;        mplier_r <= SUM_W'(n_r); end
            PR_SXSX: begin mcand_r <= SQ_W'(sx_r);  mplier_r <= sx_r;        end
            PR_NXY:  begin mcand_r <= sxy_r;        mplier_r <= SUM_W'(n_r); end
            PR_SXSY: begin mcand_r <= SQ_W'(sx_r);  mplier_r <= sy_r;        end
            PR_XXSY: begin mcand_r <= sxx_r;        mplier_r <= sy_r;        end
            default: begin mcand_r <= sxy_r;        mplier_r <= sx_r;        end
          endcase
          acc_r   <= '0;
          bit_r   <= BC_W'(SUM_W - 1);
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r    <= acc_step;
          mplier_r <= mplier_r << 1;
          bit_r    <= bit_r - BC_W'(1);
          if (bit_r == '0) begin
            prod_r[sel_r] <= acc_step;
            if (sel_r == PR_SXXY) begin
              state_r <= S_DET;
            end else begin
              sel_r   <= sel_r + 3'd1;
              state_r <= S_LOAD;
            end
          end
        end
        S_DET: begin
          det_r  <= prod_r[PR_NXX] - prod_r[PR_SXSX];
          sat_r  <= 1'b0;
          qsel_r <= Q_SLOPE;
          if (prod_r[PR_NXX] > prod_r[PR_SXSX]) begin
            state_r <= S_NUM;
          end else begin
            res_r      <= '{saturated: 1'b0, singular: 1'b1, intercept: '0, slope: '0};
            out_pend_r <= 1'b1;
            state_r    <= S_OUT_ALIAS;
          end
        end
        S_NUM: begin
          neg_r   <= lt;
          mag_r   <= lt ? d_ba : d_ab;
          state_r <= S_RND;
        end
        S_RND: begin
          // bias by half the divisor: round to nearest, ties away from zero
          dvd_r   <= (QW'(mag_r) << FRAC_W) + QW'(det_r >> 1);
          rem_r   <= '0;
          quo_r   <= '0;
          bit_r   <= BC_W'(QW - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_ge ? rem_dif[PROD_W-1:0] : rem_sh[PROD_W-1:0];
          quo_r <= {quo_r[QW-2:0], rem_ge};
          dvd_r <= dvd_r << 1;
          bit_r <= bit_r - BC_W'(1);
          if (bit_r == '0) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if (qsel_r == Q_SLOPE) begin
            res_r.slope <= slope_val;
            sat_r       <= sat_r | ovf;
            qsel_r      <= Q_ICPT;
            state_r     <= S_NUM;
          end else begin
            res_r.intercept <= icpt_val;
            res_r.saturated <= sat_r | ovf;
            res_r.singular  <= 1'b0;
            out_pend_r      <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/least_squares_line_fit_core.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit_core: line fit over sets of segments
// Streams in segments, fits y = slope * x + intercept once per set.
// ----------------------------------------------------------------------------
// Input channel (in_*): one beat per segment, two endpoints in in_tdata, and
// in_tlast marks the last segment of a set. Each endpoint counts as a point.
// Output channel (out_*): one beat per set, slope Q16.16 and intercept Q32.16
// in out_tdata, singular and saturated flags in out_tuser.
// Throughput: one segment per cycle unless a last segment waits on a full
// queue. Segments beyond MAX_SEGMENTS in a set are dropped; their tlast
// still closes the set. Each segment is registered in the product stage
// before it is summed. For each closed set the solver forms six products
// with the shift-add multiplier (SUM_W steps per product), then the slope
// and intercept with the restoring divider (one quotient bit per cycle);
// when singular, the divides are skipped. A two-entry queue holds finished
// sets so the intake keeps taking segments while a fit runs.
// Reset: synchronous, active low; clears the sums, the queue and the output.
// Stall: a held result stays in the output register; the solver waits on it,
// and once the queue is full a last segment waits at the intake.
// ----------------------------------------------------------------------------
module least_squares_line_fit_core import lslf_pkg::*; #(
  parameter  int MAX_SEGMENTS = 1024,
  parameter  int COORD_BITS   = 14,
  localparam int IN_DATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // start_x, start_y, end_x, end_y (COORD_BITS each), zero pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tlast,   // last_segment
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // slope [31:0], intercept [79:32]
  output logic [79:0]          out_tdata,
  // singular [0], saturated [1]
  output logic [1:0]           out_tuser
);

  localparam int CNT_W  = lslf_cnt_w(MAX_SEGMENTS);
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int SQ_W   = 2 * COORD_BITS + CNT_W;
  localparam int SNAP_W = 2 * SQ_W + 2 * SUM_W + CNT_W;

  logic              q_push, q_full, q_pop, q_empty;
  logic [SNAP_W-1:0] q_wdata, q_rdata;
  lslf_result_t      result;

  // Intake: products, running sums, set closing.
  lslf_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .start_x      (in_tdata[COORD_BITS-1:0]),
    .start_y      (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x        (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y        (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .last_segment (in_tlast),
    .push         (q_push),
    .push_data    (q_wdata),
    .push_full    (q_full)
  );

  // Hold up to two finished sets between intake and solver.
  lslf_fifo #(
    .WIDTH (SNAP_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Solver with its own output register.
  lslf_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tdata = {result.intercept, result.slope};
  assign out_tuser = {result.saturated, result.singular};

endmodule
